>>> design/uoa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uoa_pkg: shared types and constants for the undocumented opcode ALU
// Operation codes, status bit positions, fix-up constants and the item and
// result records passed between the pipeline registers and the datapath.
// ----------------------------------------------------------------------------
package uoa_pkg;

    // Operation codes as presented on s_kind. Codes above KIND_XXA act as NOP.
    typedef enum logic [4:0] {
        KIND_ANC = 5'd0,
        KIND_ARR = 5'd1,
        KIND_ASR = 5'd2,
        KIND_DCP = 5'd3,
        KIND_ISC = 5'd4,
        KIND_LAS = 5'd5,
        KIND_LAX = 5'd6,
        KIND_LXA = 5'd7,
        KIND_NOP = 5'd8,
        KIND_RLA = 5'd9,
        KIND_RRA = 5'd10,
        KIND_SAX = 5'd11,
        KIND_SBX = 5'd12,
        KIND_SHA = 5'd13,
        KIND_SHS = 5'd14,
        KIND_SHX = 5'd15,
        KIND_SHY = 5'd16,
        KIND_SRE = 5'd17,
        KIND_XXA = 5'd18
    } uoa_kind_t;

    // Bit positions in the status byte.
    localparam int unsigned FLAG_N = 7;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_C = 0;

    // Magic constant ORed into A by the unstable LXA and XXA operations.
    localparam logic [7:0] LXA_MAGIC     = 8'hEE;
    // Decimal adjust for one BCD digit and the largest legal digit.
    localparam logic [3:0] BCD_ADJ       = 4'h6;
    localparam logic [4:0] BCD_DIGIT_MAX = 5'd9;
    // ARR decimal fix-up: threshold on a rounded-up nibble and high-digit adjust.
    localparam logic [4:0] ARR_FIX_LIMIT = 5'd5;
    localparam logic [7:0] ARR_HI_ADJ    = 8'h60;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  acc_in;
        logic [7:0]  xreg_in;
        logic [7:0]  yreg_in;
        logic [7:0]  stack_in;
        logic [7:0]  status_in;
        logic [7:0]  operand;
        logic [15:0] base_address;
    } uoa_item_t;

    typedef struct packed {
        logic [7:0]  acc_out;
        logic [7:0]  xreg_out;
        logic [7:0]  stack_out;
        logic [7:0]  status_out;
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
    } uoa_result_t;

endpackage
`default_nettype wire

>>> design/uoa_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uoa_exec: combinational datapath for the undocumented opcode ALU
// Computes the new registers, status byte and memory write for one item.
// ----------------------------------------------------------------------------
module uoa_exec
    import uoa_pkg::*;
(
    input  uoa_item_t   item,
    output uoa_result_t result
);

    logic        c_in;
    logic [7:0]  hi1;
    logic [15:0] addr_y;
    logic [15:0] addr_x;
    logic [7:0]  m_dec;
    logic [7:0]  m_inc;
    logic [7:0]  m_rol;
    logic [7:0]  m_ror;
    logic [7:0]  m_lsr;
    logic [7:0]  and_ax;
    logic [7:0]  and_am;
    logic [7:0]  dcp_diff;
    logic [7:0]  sbx_diff;

    // SBC on the incremented operand (ISC).
    logic        sbc_b;
    logic [8:0]  sbc_diff;
    logic [4:0]  sbc_al0;
    logic [4:0]  sbc_ah0;
    logic [3:0]  sbc_al;
    logic [3:0]  sbc_ah;
    logic        sbc_v;
    logic [7:0]  sbc_res;

    // ADC on the rotated operand (RRA); carry in is the bit rotated out.
    logic        adc_ci;
    logic [8:0]  adc_sum;
    logic [4:0]  adc_al0;
    logic [5:0]  adc_al;
    logic [4:0]  adc_ah0;
    logic [5:0]  adc_ah;

    // ARR.
    logic [7:0]  arr_r0;
    logic [7:0]  arr_r1;
    logic        arr_lo_fix;
    logic        arr_hi_fix;

    logic [7:0]  a;
    logic [7:0]  st;

    assign c_in     = item.status_in[FLAG_C];
    assign hi1      = item.base_address[15:8] + 8'd1;
    assign addr_y   = item.base_address + {8'h00, item.yreg_in};
    assign addr_x   = item.base_address + {8'h00, item.xreg_in};
    assign m_dec    = item.operand - 8'd1;
    assign m_inc    = item.operand + 8'd1;
    assign m_rol    = {item.operand[6:0], c_in};
    assign m_ror    = {c_in, item.operand[7:1]};
    assign m_lsr    = {1'b0, item.operand[7:1]};
    assign and_ax   = item.acc_in & item.xreg_in;
    assign and_am   = item.acc_in & item.operand;
    assign dcp_diff = item.acc_in - m_dec;
    assign sbx_diff = and_ax - item.operand;

    assign sbc_b    = ~c_in;
    assign sbc_diff = {1'b0, item.acc_in} - {1'b0, m_inc} - {8'd0, sbc_b};
    assign sbc_al0  = {1'b0, item.acc_in[3:0]} - {1'b0, m_inc[3:0]} - {4'd0, sbc_b};
    assign sbc_ah0  = {1'b0, item.acc_in[7:4]} - {1'b0, m_inc[7:4]} - {4'd0, sbc_al0[4]};
    assign sbc_al   = sbc_al0[4] ? (sbc_al0[3:0] - BCD_ADJ) : sbc_al0[3:0];
    assign sbc_ah   = sbc_ah0[4] ? (sbc_ah0[3:0] - BCD_ADJ) : sbc_ah0[3:0];
    assign sbc_v    = (item.acc_in[7] ^ sbc_diff[7]) & (item.acc_in[7] ^ m_inc[7]);
    assign sbc_res  = item.status_in[FLAG_D] ? {sbc_ah, sbc_al} : sbc_diff[7:0];

    assign adc_ci   = item.operand[0];
    assign adc_sum  = {1'b0, item.acc_in} + {1'b0, m_ror} + {8'd0, adc_ci};
    assign adc_al0  = {1'b0, item.acc_in[3:0]} + {1'b0, m_ror[3:0]} + {4'd0, adc_ci};
    assign adc_al   = (adc_al0 > BCD_DIGIT_MAX) ? ({1'b0, adc_al0} + {2'b00, BCD_ADJ})
                                                : {1'b0, adc_al0};
    assign adc_ah0  = {1'b0, item.acc_in[7:4]} + {1'b0, m_ror[7:4]}
                      + {4'd0, (adc_al[5:4] != 2'b00)};
    assign adc_ah   = (adc_ah0 > BCD_DIGIT_MAX) ? ({1'b0, adc_ah0} + {2'b00, BCD_ADJ})
                                                : {1'b0, adc_ah0};

    assign arr_r0     = {c_in, and_am[7:1]};
    assign arr_lo_fix = ({1'b0, and_am[3:0]} + {4'd0, and_am[0]}) > ARR_FIX_LIMIT;
    assign arr_hi_fix = ({1'b0, and_am[7:4]} + {4'd0, and_am[4]}) > ARR_FIX_LIMIT;
    assign arr_r1     = arr_lo_fix ? {arr_r0[7:4], arr_r0[3:0] + BCD_ADJ} : arr_r0;

    always_comb begin
        result               = '0;
        result.acc_out       = item.acc_in;
        result.xreg_out      = item.xreg_in;
        result.stack_out     = item.stack_in;
        st                   = item.status_in;
        a                    = item.acc_in;
        case (item.kind)
            KIND_ANC: begin
                a         = and_am;
                st[FLAG_C] = and_am[7];
            end
            KIND_ARR: begin
                a          = arr_r0;
                st[FLAG_V] = and_am[6] ^ arr_r0[6];
                if (item.status_in[FLAG_D]) begin
                    a          = arr_hi_fix ? (arr_r1 + ARR_HI_ADJ) : arr_r1;
                    st[FLAG_C] = arr_hi_fix;
                end else begin
                    st[FLAG_C] = arr_r0[6];
                end
            end
            KIND_ASR: begin
                a          = {1'b0, and_am[7:1]};
                st[FLAG_C] = and_am[0];
            end
            KIND_DCP: begin
                result.write_enable = 1'b1;
                result.write_data   = m_dec;
                st[FLAG_C]          = item.acc_in >= m_dec;
            end
            KIND_ISC: begin
                result.write_enable = 1'b1;
                result.write_data   = m_inc;
                a                   = sbc_res;
                st[FLAG_V]          = sbc_v;
                st[FLAG_C]          = ~sbc_diff[8];
            end
            KIND_LAS: begin
                a                = item.operand & item.stack_in;
                result.xreg_out  = item.operand & item.stack_in;
                result.stack_out = item.operand & item.stack_in;
            end
            KIND_LAX: begin
                a               = item.operand;
                result.xreg_out = item.operand;
            end
            KIND_LXA: begin
                a               = (item.acc_in | LXA_MAGIC) & item.operand;
                result.xreg_out = (item.acc_in | LXA_MAGIC) & item.operand;
            end
            KIND_RLA: begin
                result.write_enable = 1'b1;
                result.write_data   = m_rol;
                a                   = item.acc_in & m_rol;
                st[FLAG_C]          = item.operand[7];
            end
            KIND_RRA: begin
                result.write_enable = 1'b1;
                result.write_data   = m_ror;
                if (item.status_in[FLAG_D]) begin
                    a          = {adc_ah[3:0], adc_al[3:0]};
                    st[FLAG_V] = (adc_ah0[3] ^ item.acc_in[7]) & ~(item.acc_in[7] ^ m_ror[7]);
                    st[FLAG_C] = adc_ah[5:4] != 2'b00;
                end else begin
                    a          = adc_sum[7:0];
                    st[FLAG_V] = ~(item.acc_in[7] ^ m_ror[7]) & (item.acc_in[7] ^ adc_sum[7]);
                    st[FLAG_C] = adc_sum[8];
                end
            end
            KIND_SAX: begin
                result.write_enable = 1'b1;
                result.write_data   = and_ax;
            end
            KIND_SBX: begin
                result.xreg_out = sbx_diff;
                st[FLAG_C]      = item.operand <= and_ax;
            end
            KIND_SHA: begin
                result.write_enable  = 1'b1;
                result.write_address = addr_y;
                result.write_data    = and_ax & hi1;
            end
            KIND_SHS: begin
                result.stack_out     = and_ax;
                result.write_enable  = 1'b1;
                result.write_address = addr_y;
                result.write_data    = and_ax & hi1;
            end
            KIND_SHX: begin
                result.write_enable  = 1'b1;
                result.write_address = addr_y;
                result.write_data    = item.xreg_in & hi1;
            end
            KIND_SHY: begin
                result.write_enable  = 1'b1;
                result.write_address = addr_x;
                result.write_data    = item.yreg_in & hi1;
            end
            KIND_SRE: begin
                result.write_enable = 1'b1;
                result.write_data   = m_lsr;
                a                   = item.acc_in ^ m_lsr;
                st[FLAG_C]          = item.operand[0];
            end
            KIND_XXA: begin
                a = (item.acc_in | LXA_MAGIC) & item.xreg_in & item.operand;
            end
            default: begin
                a = item.acc_in;
            end
        endcase

        // N and Z follow each op's binary result (DCP: the compare); ops not listed keep them.
        case (item.kind)
            KIND_ANC, KIND_ASR, KIND_LAS, KIND_LAX, KIND_LXA, KIND_RLA, KIND_SRE,
            KIND_XXA: begin
                st[FLAG_N] = a[7];
                st[FLAG_Z] = a == 8'h00;
            end
            KIND_ARR: begin
                st[FLAG_N] = c_in;
                st[FLAG_Z] = arr_r0 == 8'h00;
            end
            KIND_DCP: begin
                st[FLAG_N] = dcp_diff[7];
                st[FLAG_Z] = dcp_diff == 8'h00;
            end
            KIND_ISC: begin
                st[FLAG_N] = sbc_diff[7];
                st[FLAG_Z] = sbc_diff[7:0] == 8'h00;
            end
            KIND_RRA: begin
                if (item.status_in[FLAG_D]) begin
                    st[FLAG_N] = adc_ah0[3];
                    st[FLAG_Z] = adc_sum[7:0] == 8'h00;
                end else begin
                    st[FLAG_N] = adc_sum[7];
                    st[FLAG_Z] = adc_sum[7:0] == 8'h00;
                end
            end
            KIND_SBX: begin
                st[FLAG_N] = sbx_diff[7];
                st[FLAG_Z] = sbx_diff == 8'h00;
            end
            default: begin
                st = st;
            end
        endcase

        result.acc_out    = a;
        result.status_out = st;
    end

endmodule
`default_nettype wire

>>> design/undocumented_opcode_alu_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// undocumented_opcode_alu_unit: execute stage for undocumented NMOS 6502 ops
// Two-register pipeline around the combinational datapath in uoa_exec.
// ----------------------------------------------------------------------------
// This unit executes the undocumented NMOS 6502 operations (ANC, ARR, ASR,
// DCP, ISC, LAS, LAX, LXA, NOP, RLA, RRA, SAX, SBX, SHA, SHS, SHX, SHY, SRE
// and XXA) on registers and an operand that the surrounding core has already
// fetched. Each input transaction carries the operation code, A, X, Y, S,
// the status byte, the operand byte and the unindexed base address; each
// output transaction carries the new A, X, S and status byte plus an
// optional memory write. Every input transaction produces exactly one output
// transaction, in order. The unit holds an input register and a result
// register with one level of combinational logic between them (a few 8- and
// 16-bit adders plus BCD adjust); an accepted transaction is held in the input
// register, and its result is registered in the result register before it
// appears on the m_ side. A new transaction can be accepted on every cycle
// as long as the m_ side keeps taking results. When the m_ side stalls, the
// two registers fill and s_ready drops after the second transaction is held.
// Read-modify-write ops and SAX report write_address as zero because the
// write goes back to the operand's own address; SH* ops store the register
// masked with the base high byte plus one at base plus index. Operation
// codes above 18 behave as NOP.
// ----------------------------------------------------------------------------
module undocumented_opcode_alu_unit
    import uoa_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [4:0]  s_kind,
    input  wire  [7:0]  s_acc_in,
    input  wire  [7:0]  s_xreg_in,
    input  wire  [7:0]  s_yreg_in,
    input  wire  [7:0]  s_stack_in,
    input  wire  [7:0]  s_status_in,
    input  wire  [7:0]  s_operand,
    input  wire  [15:0] s_base_address,

    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_acc_out,
    output logic [7:0]  m_xreg_out,
    output logic [7:0]  m_stack_out,
    output logic [7:0]  m_status_out,
    output logic        m_write_enable,
    output logic [15:0] m_write_address,
    output logic [7:0]  m_write_data
);

    logic        in_valid_reg;
    logic        in_valid_next;
    uoa_item_t   in_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    uoa_result_t out_result_reg;
    uoa_result_t exec_result;
    logic        in_load;
    logic        out_load;

    // When the input register is full, the result register loads if it is empty or
    // its transaction is taken in the same cycle; the input register drains into it.
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg.kind         <= s_kind;
            in_item_reg.acc_in       <= s_acc_in;
            in_item_reg.xreg_in      <= s_xreg_in;
            in_item_reg.yreg_in      <= s_yreg_in;
            in_item_reg.stack_in     <= s_stack_in;
            in_item_reg.status_in    <= s_status_in;
            in_item_reg.operand      <= s_operand;
            in_item_reg.base_address <= s_base_address;
        end
        if (out_load) begin
            out_result_reg <= exec_result;
        end
    end

    uoa_exec u_exec (
        .item   (in_item_reg),
        .result (exec_result)
    );

    assign m_valid         = out_valid_reg;
    assign m_acc_out       = out_result_reg.acc_out;
    assign m_xreg_out      = out_result_reg.xreg_out;
    assign m_stack_out     = out_result_reg.stack_out;
    assign m_status_out    = out_result_reg.status_out;
    assign m_write_enable  = out_result_reg.write_enable;
    assign m_write_address = out_result_reg.write_address;
    assign m_write_data    = out_result_reg.write_data;

    // Reset empties both pipeline registers.
    assert property (@(posedge aclk) !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    // An accepted transaction always lands in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted transaction lost at input register");

    // A held input transaction keeps its contents while the result side stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && $stable(in_item_reg))
        else $error("input register changed while stalled");

    // A nonzero write address only ever comes with a write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_result_reg.write_address != 16'h0000)
        |-> out_result_reg.write_enable)
        else $error("write address without write enable");

    // A result handed on from the input register shows up as valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("result register dropped a transaction");

endmodule
`default_nettype wire
